// ===== design/local_value_numbering_table_unit_assert.svh =====
// ----------------------------------------------------------------------------
// local value numbering table assertion macros
// concurrent check helpers, clocked on i_clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef LOCAL_VALUE_NUMBERING_TABLE_UNIT_ASSERT_SVH
`define LOCAL_VALUE_NUMBERING_TABLE_UNIT_ASSERT_SVH

// same-cycle implication
`define LVN_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lvn check failed");

// next-cycle implication
`define LVN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lvn check failed");

`endif

// ===== design/lvn_pkg.sv =====
// ----------------------------------------------------------------------------
// lvn_pkg
// shared constants and controller/datapath types for the value numbering table
// ----------------------------------------------------------------------------
package lvn_pkg;

    localparam int LVN_TABLE_ENTRIES = 64;
    localparam int LVN_VREG_BITS     = 16;
    localparam int LVN_OPCODE_COUNT  = 64;

    localparam int LVN_OP_W     = 6;
    localparam int LVN_IMM_W    = 32;
    localparam int LVN_SRC_W    = 15;
    localparam int LVN_CFG_W    = 64;
    localparam int LVN_CFG_IDX_W = 2;

    localparam logic [LVN_CFG_IDX_W-1:0] CFG_PURE_OPS    = 2'd0;
    localparam logic [LVN_CFG_IDX_W-1:0] CFG_COMMUT_OPS  = 2'd1;
    localparam logic [LVN_CFG_IDX_W-1:0] CFG_BARRIER_OPS = 2'd2;

    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_stat;

endpackage

// ===== design/lvn_req_if.sv =====
// ----------------------------------------------------------------------------
// lvn_req_if
// request channel: one instruction per request
// ----------------------------------------------------------------------------
interface lvn_req_if #(
    parameter int VREG_BITS = lvn_pkg::LVN_VREG_BITS
);
    logic                              valid;
    logic                              ready;
    logic [lvn_pkg::LVN_OP_W-1:0]      op;
    logic signed [VREG_BITS-1:0]       first_operand;
    logic signed [VREG_BITS-1:0]       second_operand;
    logic signed [lvn_pkg::LVN_IMM_W-1:0] immediate;
    logic                              is_float;
    logic signed [VREG_BITS-1:0]       destination;
    logic                              starts_block;

    modport source (
        output valid, op, first_operand, second_operand, immediate, is_float,
               destination, starts_block,
        input  ready
    );

    modport sink (
        input  valid, op, first_operand, second_operand, immediate, is_float,
               destination, starts_block,
        output ready
    );
endinterface

// ===== design/lvn_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lvn_rsp_if
// result channel: copy decision and clear flag per request
// ----------------------------------------------------------------------------
interface lvn_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          becomes_copy;
    logic [lvn_pkg::LVN_SRC_W-1:0] copy_source;
    logic                          table_cleared;

    modport source (
        output valid, becomes_copy, copy_source, table_cleared,
        input  ready
    );

    modport sink (
        input  valid, becomes_copy, copy_source, table_cleared,
        output ready
    );
endinterface

// ===== design/lvn_ctrl.sv =====
// ----------------------------------------------------------------------------
// lvn_ctrl
// request sequencing: load, table scan, result write-back
// ----------------------------------------------------------------------------
module lvn_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  lvn_pkg::t_stat i_stat,
    output lvn_pkg::t_cmd  o_cmd
);
    import lvn_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.load  = i_req_valid;
                if (i_req_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan   = !i_stat.scan_done;
                o_cmd.finish = i_stat.scan_done && i_stat.out_free;
                if (o_cmd.finish) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== design/lvn_dp.sv =====
// ----------------------------------------------------------------------------
// lvn_dp
// masks, request registers, expression table memory, scan compare, result register
// ----------------------------------------------------------------------------
`include "local_value_numbering_table_unit_assert.svh"

module lvn_dp #(
    parameter int TABLE_ENTRIES = lvn_pkg::LVN_TABLE_ENTRIES,
    parameter int VREG_BITS     = lvn_pkg::LVN_VREG_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_wr_en,
    input  logic [lvn_pkg::LVN_CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lvn_pkg::LVN_CFG_W-1:0]          i_cfg_wdata,
    input  lvn_pkg::t_cmd                          i_cmd,
    output lvn_pkg::t_stat                         o_stat,
    input  logic [lvn_pkg::LVN_OP_W-1:0]           i_op,
    input  logic signed [VREG_BITS-1:0]            i_first_operand,
    input  logic signed [VREG_BITS-1:0]            i_second_operand,
    input  logic signed [lvn_pkg::LVN_IMM_W-1:0]   i_immediate,
    input  logic                                   i_is_float,
    input  logic signed [VREG_BITS-1:0]            i_destination,
    input  logic                                   i_starts_block,
    lvn_rsp_if.source                              o_rsp
);
    import lvn_pkg::*;

    localparam int CNT_W     = $clog2(TABLE_ENTRIES + 1);
    localparam int IDX_W     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int REG_W     = VREG_BITS - 1;
    localparam int KEY_W     = LVN_OP_W + 2 * VREG_BITS + 1;
    localparam int ENTRY_W   = KEY_W + LVN_IMM_W + REG_W;
    localparam int SRC_EXT_W = REG_W + LVN_SRC_W;

    logic [LVN_CFG_W-1:0] r_pure_mask;
    logic [LVN_CFG_W-1:0] r_commut_mask;
    logic [LVN_CFG_W-1:0] r_barrier_mask;

    logic [KEY_W-1:0]     r_key;
    logic [LVN_IMM_W-1:0] r_imm;
    logic [VREG_BITS-1:0] r_dst;
    logic                 r_pure;
    logic                 r_barrier;
    logic                 r_start;

    logic [ENTRY_W-1:0]   r_mem [TABLE_ENTRIES];
    logic [ENTRY_W-1:0]   r_rd_data;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     r_rd_idx;
    logic                 r_cmp_pend;

    logic                 r_out_valid;
    logic                 r_out_copy;
    logic [LVN_SRC_W-1:0] r_out_src;
    logic                 r_out_cleared;

    logic                 w_op_ok;
    logic                 w_swap;
    logic [VREG_BITS-1:0] w_lo;
    logic [VREG_BITS-1:0] w_hi;
    logic                 w_issue;
    logic                 w_match;
    logic                 w_insert;
    logic                 w_clear_end;
    logic [REG_W-1:0]     w_rd_reg;
    logic [SRC_EXT_W-1:0] w_src_ext;

    // opcode decode and operand ordering
    assign w_op_ok = {1'b0, i_op} < (LVN_OP_W + 1)'(LVN_OPCODE_COUNT);
    assign w_swap  = w_op_ok && r_commut_mask[i_op] &&
                     (i_first_operand > i_second_operand);
    assign w_lo    = w_swap ? i_second_operand : i_first_operand;
    assign w_hi    = w_swap ? i_first_operand : i_second_operand;

    // scan compare
    assign w_issue   = i_cmd.scan && r_pure && (r_rd_idx < r_count);
    assign w_match   = r_cmp_pend &&
                       (r_rd_data[ENTRY_W-1 -: KEY_W] == r_key) &&
                       (r_rd_data[REG_W +: LVN_IMM_W] == r_imm);
    assign w_rd_reg  = r_rd_data[REG_W-1:0];
    assign w_src_ext = SRC_EXT_W'(w_rd_reg);

    assign w_insert    = i_cmd.finish && r_pure && !w_match && !r_dst[VREG_BITS-1] &&
                         (r_count < CNT_W'(TABLE_ENTRIES));
    assign w_clear_end = i_cmd.finish && !r_pure && r_barrier;

    assign o_stat.scan_done = !r_pure || w_match || (!r_cmp_pend && (r_rd_idx >= r_count));
    assign o_stat.out_free  = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pure_mask    <= '0;
            r_commut_mask  <= '0;
            r_barrier_mask <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_PURE_OPS:    r_pure_mask    <= i_cfg_wdata;
                CFG_COMMUT_OPS:  r_commut_mask  <= i_cfg_wdata;
                CFG_BARRIER_OPS: r_barrier_mask <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // request registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key     <= {i_op, w_lo, w_hi, i_is_float};
            r_imm     <= i_immediate;
            r_dst     <= i_destination;
            r_pure    <= w_op_ok && r_pure_mask[i_op];
            r_barrier <= w_op_ok && r_barrier_mask[i_op];
            r_start   <= i_starts_block;
        end
    end

    // table memory
    always_ff @(posedge i_clk) begin
        if (w_insert) begin
            r_mem[r_count[IDX_W-1:0]] <= {r_key, r_imm, r_dst[REG_W-1:0]};
        end
        if (w_issue) begin
            r_rd_data <= r_mem[r_rd_idx[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_rd_idx   <= '0;
            r_cmp_pend <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_rd_idx   <= '0;
                r_cmp_pend <= 1'b0;
                if (i_starts_block) begin
                    r_count <= '0;
                end
            end else if (i_cmd.scan) begin
                r_cmp_pend <= w_issue;
                r_rd_idx   <= r_rd_idx + CNT_W'(w_issue);
            end
            if (w_insert) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_clear_end) begin
                r_count <= '0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_copy    <= w_match;
            r_out_src     <= w_match ? w_src_ext[LVN_SRC_W-1:0] : '0;
            r_out_cleared <= r_start || (!r_pure && r_barrier);
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.becomes_copy  = r_out_copy;
    assign o_rsp.copy_source   = r_out_src;
    assign o_rsp.table_cleared = r_out_cleared;

    `LVN_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(TABLE_ENTRIES))
    `LVN_ASSERT_NOW(a_finish_slot_free, i_cmd.finish, !r_out_valid || o_rsp.ready)
    `LVN_ASSERT_NEXT(a_finish_shows_result, i_cmd.finish, r_out_valid)
    `LVN_ASSERT_NEXT(a_block_start_clears, i_cmd.load && i_starts_block, r_count == '0)

endmodule

// ===== design/local_value_numbering_table_unit.sv =====
// ----------------------------------------------------------------------------
// local_value_numbering_table_unit
// common subexpression lookup table for one basic block at a time
//
//   channel   dir   handshake      contents
//   i_req     in    valid/ready    opcode, operands, immediate, float, dest, block start
//   o_rsp     out   valid/ready    copy flag, copy source register, table cleared
//   i_cfg_*   in    write enable   pure, commutative and barrier opcode masks
//
// one request at a time; when the opcode is not numbered there is no table scan, otherwise
// the scan reads the table memory one entry per cycle, up to the fill count
// a hit ends the scan early
// reset empties the table and clears the masks, no clearing pass
// a request is taken while the previous result still waits; a stalled result
// holds back only the write-back of the next one
// ----------------------------------------------------------------------------
module local_value_numbering_table_unit #(
    parameter int TABLE_ENTRIES = lvn_pkg::LVN_TABLE_ENTRIES,
    parameter int VREG_BITS     = lvn_pkg::LVN_VREG_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [lvn_pkg::LVN_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lvn_pkg::LVN_CFG_W-1:0]     i_cfg_wdata,
    lvn_req_if.sink                           i_req,
    lvn_rsp_if.source                         o_rsp
);
    import lvn_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_ready;

    assign i_req.ready = w_ready;

    lvn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    lvn_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .VREG_BITS     (VREG_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_op             (i_req.op),
        .i_first_operand  (i_req.first_operand),
        .i_second_operand (i_req.second_operand),
        .i_immediate      (i_req.immediate),
        .i_is_float       (i_req.is_float),
        .i_destination    (i_req.destination),
        .i_starts_block   (i_req.starts_block),
        .o_rsp            (o_rsp)
    );

endmodule

// ===== dv/tb_local_value_numbering_table_unit.sv =====
// ----------------------------------------------------------------------------
// tb_local_value_numbering_table_unit
// checks the value numbering table against an in-bench copy of the expression
// table: directed cases, a full table, mask extremes and random basic blocks,
// with random request gaps and result stalls, every result compared in order
// ----------------------------------------------------------------------------
module tb_local_value_numbering_table_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import lvn_pkg::*;

    localparam int TABLE_ENTRIES  = LVN_TABLE_ENTRIES;
    localparam int VREG_W         = LVN_VREG_BITS;
    localparam int KEY_W          = LVN_OP_W + 2 * VREG_W + 1;
    localparam int TOTAL_REQUESTS = 650;
    localparam int CYCLE_LIMIT    = 500000;
    localparam int PRINT_LIMIT    = 40;

    localparam logic [LVN_OP_W-1:0] OP_LABEL = 6'd0;
    localparam logic [LVN_OP_W-1:0] OP_ADD   = 6'd1;
    localparam logic [LVN_OP_W-1:0] OP_SUB   = 6'd2;
    localparam logic [LVN_OP_W-1:0] OP_FENCE = 6'd5;
    localparam logic [LVN_OP_W-1:0] OP_STORE = 6'd20;
    localparam logic [LVN_OP_W-1:0] OP_JUMP  = 6'd40;
    localparam logic [LVN_OP_W-1:0] OP_TOP   = 6'd63;

    localparam logic [LVN_CFG_W-1:0] ALL_OPS = {LVN_CFG_W{1'b1}};
    localparam logic [LVN_CFG_W-1:0] NO_OPS  = '0;

    localparam logic signed [LVN_IMM_W-1:0] IMM_MIN = 32'sh8000_0000;
    localparam logic signed [LVN_IMM_W-1:0] IMM_MAX = 32'sh7fff_ffff;

    typedef struct {
        logic [LVN_OP_W-1:0]         op;
        logic signed [VREG_W-1:0]    first_operand;
        logic signed [VREG_W-1:0]    second_operand;
        logic signed [LVN_IMM_W-1:0] immediate;
        logic                        is_float;
        logic signed [VREG_W-1:0]    destination;
        logic                        starts_block;
    } t_lvn_instr;

    typedef struct {
        logic                 becomes_copy;
        logic [LVN_SRC_W-1:0] copy_source;
        logic                 table_cleared;
    } t_lvn_verdict;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_wr_en;
    logic [LVN_CFG_IDX_W-1:0] i_cfg_index;
    logic [LVN_CFG_W-1:0]     i_cfg_wdata;

    lvn_req_if req_ch ();
    lvn_rsp_if rsp_ch ();

    local_value_numbering_table_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    // expression table copy
    logic [LVN_CFG_W-1:0]  pure_mask;
    logic [LVN_CFG_W-1:0]  commut_mask;
    logic [LVN_CFG_W-1:0]  barrier_mask;
    logic [KEY_W-1:0]      cse_key [TABLE_ENTRIES];
    logic [LVN_IMM_W-1:0]  cse_imm [TABLE_ENTRIES];
    logic [LVN_SRC_W-1:0]  cse_reg [TABLE_ENTRIES];
    logic                  cse_live [TABLE_ENTRIES];
    int                    cse_fill;

    t_lvn_verdict pending_verdicts [$];
    int           mismatch_count;
    int           requests_sent;
    int           burst_left;
    int           cycle_count;

    logic [31:0] stall_bits;
    logic [4:0]  stall_phase;

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result stall pattern, redrawn whenever the phase counter wraps
    always @(posedge i_clk) begin
        if (stall_phase == '0) begin
            case ($urandom_range(0, 3))
                0: begin
                    stall_bits <= '1;
                end
                1: begin
                    stall_bits <= $urandom | $urandom;
                end
                default: begin
                    stall_bits <= $urandom;
                end
            endcase
        end
        stall_phase  <= stall_phase + 5'd1;
        rsp_ch.ready <= stall_bits[stall_phase];
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
        mismatch_count++;
    endtask

    function automatic void wipe_table();
        foreach (cse_live[i]) cse_live[i] = 1'b0;
        cse_fill = 0;
    endfunction

    function automatic t_lvn_verdict number_value(input t_lvn_instr ins);
        t_lvn_verdict             v;
        logic signed [VREG_W-1:0] lo;
        logic signed [VREG_W-1:0] hi;
        logic [KEY_W-1:0]         key;
        bit                       hit;
        v.becomes_copy  = 1'b0;
        v.copy_source   = '0;
        v.table_cleared = 1'b0;
        hit = 1'b0;
        if (ins.starts_block) begin
            wipe_table();
            v.table_cleared = 1'b1;
        end
        if (pure_mask[ins.op]) begin
            lo = ins.first_operand;
            hi = ins.second_operand;
            if (commut_mask[ins.op] && ins.first_operand > ins.second_operand) begin
                lo = ins.second_operand;
                hi = ins.first_operand;
            end
            key = {ins.op, lo, hi, ins.is_float};
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (!hit && cse_live[i] && cse_key[i] == key && cse_imm[i] == ins.immediate) begin
                    hit = 1'b1;
                    v.copy_source = cse_reg[i];
                end
            end
            if (hit) begin
                v.becomes_copy = 1'b1;
            end else if (!ins.destination[VREG_W-1] && cse_fill < TABLE_ENTRIES) begin
                cse_key[cse_fill]  = key;
                cse_imm[cse_fill]  = ins.immediate;
                cse_reg[cse_fill]  = ins.destination[LVN_SRC_W-1:0];
                cse_live[cse_fill] = 1'b1;
                cse_fill++;
            end
        end else if (barrier_mask[ins.op]) begin
            wipe_table();
            v.table_cleared = 1'b1;
        end
        return v;
    endfunction

    always @(posedge i_clk) begin
        t_lvn_verdict want;
        if (i_rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                want = pending_verdicts.pop_front();
                if (rsp_ch.becomes_copy !== want.becomes_copy)
                    report_mismatch($sformatf("becomes_copy got %b want %b",
                                              rsp_ch.becomes_copy, want.becomes_copy));
                if (rsp_ch.copy_source !== want.copy_source)
                    report_mismatch($sformatf("copy_source got %0d want %0d",
                                              rsp_ch.copy_source, want.copy_source));
                if (rsp_ch.table_cleared !== want.table_cleared)
                    report_mismatch($sformatf("table_cleared got %b want %b",
                                              rsp_ch.table_cleared, want.table_cleared));
            end
        end
    end

    function automatic t_lvn_instr make_instr(
        input logic [LVN_OP_W-1:0]         op,
        input logic signed [VREG_W-1:0]    a,
        input logic signed [VREG_W-1:0]    b,
        input logic signed [LVN_IMM_W-1:0] imm,
        input logic                        fl,
        input logic signed [VREG_W-1:0]    dst,
        input logic                        start
    );
        t_lvn_instr ins;
        ins.op             = op;
        ins.first_operand  = a;
        ins.second_operand = b;
        ins.immediate      = imm;
        ins.is_float       = fl;
        ins.destination    = dst;
        ins.starts_block   = start;
        return ins;
    endfunction

    function automatic logic signed [VREG_W-1:0] pool_vreg();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return -1;
        if (r <= 6) return VREG_W'($urandom_range(0, 7));
        if (r == 7) return 32767;
        return VREG_W'($urandom_range(0, 32767));
    endfunction

    function automatic logic signed [VREG_W-1:0] rand_dest();
        if ($urandom_range(0, 9) == 0) return -1;
        return VREG_W'($urandom_range(0, 32767));
    endfunction

    function automatic logic [LVN_OP_W-1:0] op_in(input logic [LVN_CFG_W-1:0] mask);
        logic [LVN_OP_W-1:0] op;
        op = LVN_OP_W'($urandom_range(0, 63));
        if (mask == '0) return op;
        while (!mask[op]) op = LVN_OP_W'($urandom_range(0, 63));
        return op;
    endfunction

    task automatic send_request(input t_lvn_instr ins);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        req_ch.valid          <= 1'b1;
        req_ch.op             <= ins.op;
        req_ch.first_operand  <= ins.first_operand;
        req_ch.second_operand <= ins.second_operand;
        req_ch.immediate      <= ins.immediate;
        req_ch.is_float       <= ins.is_float;
        req_ch.destination    <= ins.destination;
        req_ch.starts_block   <= ins.starts_block;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) @(posedge i_clk);
        pending_verdicts.push_back(number_value(ins));
        requests_sent++;
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_masks(
        input logic [LVN_CFG_W-1:0] pure_bits,
        input logic [LVN_CFG_W-1:0] commut_bits,
        input logic [LVN_CFG_W-1:0] barrier_bits
    );
        wait_idle();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_PURE_OPS;
        i_cfg_wdata <= pure_bits;
        @(posedge i_clk);
        i_cfg_index <= CFG_COMMUT_OPS;
        i_cfg_wdata <= commut_bits;
        @(posedge i_clk);
        i_cfg_index <= CFG_BARRIER_OPS;
        i_cfg_wdata <= barrier_bits;
        @(posedge i_clk);
        i_cfg_wr_en  <= 1'b0;
        pure_mask    = pure_bits;
        commut_mask  = commut_bits;
        barrier_mask = barrier_bits;
    endtask

    // one basic block: a block start, then mostly numbered ops with repeats
    task automatic run_block(input int len);
        t_lvn_instr               seen [$];
        t_lvn_instr               ins;
        logic signed [VREG_W-1:0] tmp;
        int                       pick;
        int                       kind;
        for (int n = 0; n < len; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                ins = make_instr(LVN_OP_W'($urandom_range(0, 63)),
                                 VREG_W'($urandom_range(0, 32767)), -1, $urandom,
                                 1'($urandom_range(0, 1)), rand_dest(), 1'b0);
                if ($urandom_range(0, 1)) ins.second_operand = VREG_W'($urandom_range(0, 32767));
            end else if (seen.size() > 0 && pick < 45) begin
                ins = seen[$urandom_range(0, seen.size() - 1)];
                if ($urandom_range(0, 1)) begin
                    tmp = ins.first_operand;
                    ins.first_operand  = ins.second_operand;
                    ins.second_operand = tmp;
                end
                ins.destination = rand_dest();
            end else begin
                kind = $urandom_range(0, 99);
                if (kind < 85) ins.op = op_in(pure_mask);
                else if (kind < 93) ins.op = op_in(~(pure_mask | barrier_mask));
                else ins.op = op_in(barrier_mask);
                ins.first_operand  = pool_vreg();
                ins.second_operand = pool_vreg();
                case ($urandom_range(0, 5))
                    0, 1: begin
                        ins.immediate = $urandom_range(0, 3);
                    end
                    2: begin
                        ins.immediate = -1;
                    end
                    3: begin
                        ins.immediate = $urandom_range(0, 1) ? IMM_MIN : IMM_MAX;
                    end
                    default: begin
                        ins.immediate = $urandom;
                    end
                endcase
                ins.is_float    = 1'($urandom_range(0, 1));
                ins.destination = rand_dest();
                seen.push_back(ins);
            end
            ins.starts_block = (n == 0) || ($urandom_range(0, 49) == 0);
            send_request(ins);
        end
    endtask

    task automatic test_unconfigured();
        send_request(make_instr(OP_ADD, 1, 2, 0, 0, 10, 1'b1));
        send_request(make_instr(OP_ADD, 1, 2, 0, 0, 11, 1'b0));
        send_request(make_instr(OP_JUMP, -1, -1, 0, 0, -1, 1'b0));
        send_request(make_instr(OP_ADD, 1, 2, 0, 0, 12, 1'b0));
    endtask

    task automatic test_directed();
        load_masks((64'd1 << OP_ADD) | (64'd1 << OP_SUB) | (64'd1 << OP_FENCE) |
                       (64'd1 << OP_TOP),
                   (64'd1 << OP_ADD) | (64'd1 << OP_TOP),
                   (64'd1 << OP_LABEL) | (64'd1 << OP_FENCE) | (64'd1 << OP_JUMP));
        send_request(make_instr(OP_ADD, 1, 2, 0, 0, 10, 1'b1));
        send_request(make_instr(OP_ADD, 2, 1, 0, 0, 11, 1'b0));
        send_request(make_instr(OP_SUB, 1, 2, 0, 0, 12, 1'b0));
        send_request(make_instr(OP_SUB, 2, 1, 0, 0, 13, 1'b0));
        send_request(make_instr(OP_SUB, 1, 2, 0, 0, 14, 1'b0));
        send_request(make_instr(OP_TOP, -1, 32767, IMM_MAX, 1, 32767, 1'b0));
        send_request(make_instr(OP_TOP, 32767, -1, IMM_MAX, 1, 5, 1'b0));
        // negative destination leaves nothing behind
        send_request(make_instr(OP_TOP, 32767, -1, IMM_MAX, 0, -1, 1'b0));
        send_request(make_instr(OP_TOP, -1, 32767, IMM_MAX, 0, 6, 1'b0));
        send_request(make_instr(OP_SUB, -1, -1, IMM_MIN, 1, 0, 1'b0));
        send_request(make_instr(OP_SUB, -1, -1, IMM_MIN, 1, 7, 1'b0));
        // pure and barrier at once keeps the table
        send_request(make_instr(OP_FENCE, 3, 4, 0, 0, 20, 1'b0));
        send_request(make_instr(OP_ADD, 1, 2, 0, 0, 21, 1'b0));
        send_request(make_instr(OP_STORE, 1, 2, 0, 0, 22, 1'b0));
        send_request(make_instr(OP_ADD, 2, 1, 0, 0, 23, 1'b0));
        send_request(make_instr(OP_JUMP, -1, -1, 0, 0, -1, 1'b0));
        send_request(make_instr(OP_ADD, 1, 2, 0, 0, 24, 1'b0));
        send_request(make_instr(OP_LABEL, -1, -1, 0, 0, -1, 1'b1));
        send_request(make_instr(OP_ADD, 1, 2, 0, 0, 25, 1'b0));
        send_request(make_instr(OP_ADD, 1, 2, 0, 0, 26, 1'b1));
        send_request(make_instr(OP_ADD, 1, 2, 1, 0, 27, 1'b0));
        send_request(make_instr(OP_ADD, 1, 2, 1, 0, 28, 1'b0));
    endtask

    task automatic test_table_full();
        t_lvn_instr head;
        t_lvn_instr tail;
        t_lvn_instr extra;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            tail = make_instr(OP_SUB, VREG_W'(i), VREG_W'($urandom_range(0, 32767)), $urandom,
                              1'($urandom_range(0, 1)), VREG_W'(100 + i), i == 0);
            if (i == 0) head = tail;
            send_request(tail);
        end
        extra = make_instr(OP_SUB, 32767, 32767, 9, 0, 300, 1'b0);
        send_request(extra);
        send_request(make_instr(OP_ADD, 5, 6, 9, 1, 301, 1'b0));
        extra.destination = 302;
        send_request(extra);
        head.destination = 303;
        send_request(head);
        tail.destination = 304;
        send_request(tail);
    endtask

    task automatic test_mask_extremes();
        load_masks(ALL_OPS, ALL_OPS, ALL_OPS);
        run_block(30);
        load_masks(NO_OPS, ALL_OPS, ALL_OPS);
        run_block(15);
        load_masks(ALL_OPS, NO_OPS, NO_OPS);
        run_block(25);
        load_masks(NO_OPS, NO_OPS, NO_OPS);
        run_block(8);
    endtask

    task automatic test_random_blocks();
        logic [LVN_CFG_W-1:0] pure_bits;
        logic [LVN_CFG_W-1:0] commut_bits;
        logic [LVN_CFG_W-1:0] barrier_bits;
        while (requests_sent < TOTAL_REQUESTS) begin
            pure_bits    = {$urandom, $urandom} | {$urandom, $urandom};
            commut_bits  = {$urandom, $urandom};
            barrier_bits = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            if ($urandom_range(0, 3) == 0) pure_bits = {$urandom, $urandom};
            load_masks(pure_bits, commut_bits, barrier_bits);
            repeat ($urandom_range(2, 6)) begin
                run_block(($urandom_range(0, 9) == 0) ? $urandom_range(60, 90)
                                                      : $urandom_range(1, 30));
            end
        end
    endtask

    initial begin
        i_rst_n               = 1'b0;
        i_cfg_wr_en           = 1'b0;
        i_cfg_index           = CFG_PURE_OPS;
        i_cfg_wdata           = '0;
        req_ch.valid          = 1'b0;
        req_ch.op             = '0;
        req_ch.first_operand  = '0;
        req_ch.second_operand = '0;
        req_ch.immediate      = '0;
        req_ch.is_float       = 1'b0;
        req_ch.destination    = '0;
        req_ch.starts_block   = 1'b0;
        rsp_ch.ready          = 1'b0;
        stall_bits            = '1;
        stall_phase           = '0;
        cycle_count           = 0;
        mismatch_count        = 0;
        requests_sent         = 0;
        burst_left            = 0;
        pure_mask             = '0;
        commut_mask           = '0;
        barrier_mask          = '0;
        wipe_table();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_unconfigured();
        test_directed();
        test_table_full();
        test_mask_extremes();
        test_random_blocks();

        wait_idle();
        repeat (TABLE_ENTRIES + 4) @(posedge i_clk);
        if (pending_verdicts.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_verdicts.size()));
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/lvn_pkg.sv
design/lvn_req_if.sv
design/lvn_rsp_if.sv
design/lvn_ctrl.sv
design/lvn_dp.sv
design/local_value_numbering_table_unit.sv
dv/tb_local_value_numbering_table_unit.sv
